// ----- rtl/iphsv_pkg.sv -----
// iphsv_pkg: shared constants and types for the palette hsv-to-rgb block
// no dependencies; imported by index_palette_hsv_to_rgb, palette_color_checker and tb_top

package iphsv_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned INDEX_BITS_DEF    = 16;
  localparam int unsigned MAX_INDEX_BITS    = 24;

  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned OUT_W   = 3 * CHAN_W;
  localparam int unsigned SEC_W   = 3;

  localparam logic [CFG_W-1:0]  CFG_ONE           = 17'h10000;
  localparam logic [SIZE_W-1:0] PALETTE_SIZE_RST  = 16'd1;
  localparam logic [CFG_W-1:0]  SATURATION_RST    = 17'd55706;
  localparam logic [CFG_W-1:0]  VALUE_LEVEL_RST   = 17'd62259;

  typedef enum logic [1:0] {
    REG_PALETTE_SIZE = 2'd0,
    REG_SATURATION   = 2'd1,
    REG_VALUE_LEVEL  = 2'd2
  } reg_idx_e;

  // hue sextants, red through magenta
  typedef enum logic [SEC_W-1:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  localparam logic [SEC_W-1:0] SECTOR_COUNT = 3'd6;

  // (2*sec + b) mod 6 for sec < 6
  function automatic logic [SEC_W-1:0] sec_step(logic [SEC_W-1:0] sec, logic b);
    logic [SEC_W:0] t;
    t = {sec, b};
    if (t >= {1'b0, SECTOR_COUNT}) begin
      t = t - {1'b0, SECTOR_COUNT};
    end
    return t[SEC_W-1:0];
  endfunction

endpackage

// ----- rtl/index_palette_hsv_to_rgb.sv -----
// index_palette_hsv_to_rgb: palette index to 8-bit rgb through a pipelined hsv conversion
// bit-serial restoring divider stages, then multiply and sextant select stages
// depends on iphsv_pkg
//
//  channel | transaction                          | fields (lsb first)
//  --------+--------------------------------------+-------------------------------
//  s_axis  | index in, tvalid/tready              | tdata: color_index[15:0]
//  m_axis  | color out, tvalid/tready             | tdata: red, green, blue
//  apb     | register write/read, pready always 1 | 0x0 size, 0x4 sat, 0x8 value
//
// one bit of quotient per divider stage, then product, select, value product and scale stages
// one transaction per cycle sustained while m_axis_tready is high; every stage holds its own valid bit
// a stalled output only blocks the stages behind it that are full; bubbles close up
// reset clears the valid bits and loads the register defaults; no clearing pass

module index_palette_hsv_to_rgb #(
  parameter int unsigned FRACTION_BITS = iphsv_pkg::FRACTION_BITS_DEF,
  parameter int unsigned INDEX_BITS    = iphsv_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [iphsv_pkg::ADDR_W-1:0]    paddr,
  input  logic [iphsv_pkg::DATA_W-1:0]    pwdata,
  output logic [iphsv_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [iphsv_pkg::IN_W-1:0]      s_axis_tdata,  // color_index[15:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [iphsv_pkg::OUT_W-1:0]     m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

  import iphsv_pkg::*;

  localparam int unsigned NUM_W      = INDEX_BITS + 3;
  localparam int unsigned DIV_STAGES = NUM_W + FRACTION_BITS;
  localparam int unsigned ST_FS      = DIV_STAGES;
  localparam int unsigned ST_SEL     = DIV_STAGES + 1;
  localparam int unsigned ST_MUL     = DIV_STAGES + 2;
  localparam int unsigned ST_OUT     = DIV_STAGES + 3;
  localparam int unsigned NUM_ST     = DIV_STAGES + 4;
  localparam int unsigned A_W        = FRACTION_BITS + CFG_W;
  localparam int unsigned P_W        = A_W + CFG_W;
  localparam int unsigned SC_W       = P_W + CHAN_W;
  localparam int unsigned SH         = 32 + FRACTION_BITS;

  localparam logic [A_W-1:0] A_ONE = {1'b1, {(A_W-1){1'b0}}};

  // configuration registers
  logic [SIZE_W-1:0] palette_size_q;
  logic [CFG_W-1:0]  saturation_q;
  logic [CFG_W-1:0]  value_level_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= PALETTE_SIZE_RST;
      saturation_q   <= SATURATION_RST;
      value_level_q  <= VALUE_LEVEL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PALETTE_SIZE: palette_size_q <= pwdata[SIZE_W-1:0];
        REG_SATURATION:   saturation_q   <= pwdata[CFG_W-1:0];
        REG_VALUE_LEVEL:  value_level_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PALETTE_SIZE: prdata = {{(DATA_W-SIZE_W){1'b0}}, palette_size_q};
      REG_SATURATION:   prdata = {{(DATA_W-CFG_W){1'b0}}, saturation_q};
      REG_VALUE_LEVEL:  prdata = {{(DATA_W-CFG_W){1'b0}}, value_level_q};
      default:          prdata = '0;
    endcase
  end

  logic [SIZE_W-1:0] n_c;
  logic [CFG_W-1:0]  s_c;
  logic [CFG_W-1:0]  v_c;

  assign n_c = (palette_size_q == '0) ? PALETTE_SIZE_RST : palette_size_q;
  assign s_c = (saturation_q  > CFG_ONE) ? CFG_ONE : saturation_q;
  assign v_c = (value_level_q > CFG_ONE) ? CFG_ONE : value_level_q;

  // valid bits and per-stage load enables
  logic [NUM_ST-1:0] vld_q;
  logic [NUM_ST-1:0] vld_d;
  logic [NUM_ST-1:0] en;

  for (genvar k = 0; k < NUM_ST; k++) begin : g_en
    assign en[k] = m_axis_tready | ~(&vld_q[NUM_ST-1:k]);
  end

  assign vld_d = (en & {vld_q[NUM_ST-2:0], s_axis_tvalid}) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[ST_OUT];

  // dividend 3*(2*index+1), shifted left by FRACTION_BITS through the stages
  logic [MAX_INDEX_BITS-1:0] idx_ext;
  logic [INDEX_BITS-1:0]     idx;
  logic [NUM_W-1:0]          num_in;

  assign idx_ext = MAX_INDEX_BITS'(s_axis_tdata);
  assign idx     = idx_ext[INDEX_BITS-1:0];
  assign num_in  = ({3'b000, idx} << 2) + ({3'b000, idx} << 1) + NUM_W'(3);

  logic [SIZE_W-1:0]        rem_q  [DIV_STAGES-1];
  logic [NUM_W-1:0]         num_q  [NUM_W-1];
  logic [SEC_W-1:0]         sec_q  [DIV_STAGES];
  logic [FRACTION_BITS-1:0] frac_q [FRACTION_BITS];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [SIZE_W-1:0] rem_in;
    logic [SEC_W-1:0]  sec_in;
    logic              bit_in;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign sec_in = '0;
      assign bit_in = num_in[NUM_W-1];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign sec_in = sec_q[k-1];
      if (k < NUM_W) begin : g_int_bit
        assign bit_in = num_q[k-1][NUM_W-1];
      end else begin : g_frac_bit
        assign bit_in = 1'b0;
      end
    end

    assign trial = {rem_in, bit_in};
    assign diff  = trial - {1'b0, n_c};
    assign ge    = (trial >= {1'b0, n_c});

    if (k < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          rem_q[k] <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        end
      end
    end

    if (k < NUM_W - 1) begin : g_num
      if (k == 0) begin : g_num_first
        always_ff @(posedge clk_i) begin
          if (en[k]) begin
            num_q[k] <= num_in << 1;
          end
        end
      end else begin : g_num_next
        always_ff @(posedge clk_i) begin
          if (en[k]) begin
            num_q[k] <= num_q[k-1] << 1;
          end
        end
      end
    end

    if (k < NUM_W) begin : g_sec_int
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          sec_q[k] <= sec_step(sec_in, ge);
        end
      end
    end else begin : g_sec_frac
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          sec_q[k] <= sec_in;
        end
      end
      if (k == NUM_W) begin : g_frac_first
        always_ff @(posedge clk_i) begin
          if (en[k]) begin
            frac_q[k-NUM_W] <= FRACTION_BITS'(ge);
          end
        end
      end else begin : g_frac_next
        always_ff @(posedge clk_i) begin
          if (en[k]) begin
            frac_q[k-NUM_W] <= {frac_q[k-NUM_W-1][FRACTION_BITS-2:0], ge};
          end
        end
      end
    end
  end

  // f * s
  logic [A_W-1:0]   fs_d;
  logic [A_W-1:0]   fs_q;
  logic [SEC_W-1:0] sec_fs_q;

  assign fs_d = A_W'(frac_q[FRACTION_BITS-1]) * A_W'(s_c);

  always_ff @(posedge clk_i) begin
    if (en[ST_FS]) begin
      fs_q     <= fs_d;
      sec_fs_q <= sec_q[DIV_STAGES-1];
    end
  end

  // p, q, t in units of 2^-(16+FRACTION_BITS), then sextant permutation
  logic [A_W-1:0] ap;
  logic [A_W-1:0] aq;
  logic [A_W-1:0] at;
  logic [A_W-1:0] a_d [3];
  logic [A_W-1:0] a_q [3];
  logic [CFG_W-1:0] one_minus_s;

  assign one_minus_s = CFG_ONE - s_c;
  assign ap = {one_minus_s, {FRACTION_BITS{1'b0}}};
  assign aq = A_ONE - fs_q;
  assign at = A_ONE - {s_c, {FRACTION_BITS{1'b0}}} + fs_q;

  always_comb begin
    case (sector_e'(sec_fs_q))
      SEC_RY: begin
        a_d[0] = A_ONE; a_d[1] = at;    a_d[2] = ap;
      end
      SEC_YG: begin
        a_d[0] = aq;    a_d[1] = A_ONE; a_d[2] = ap;
      end
      SEC_GC: begin
        a_d[0] = ap;    a_d[1] = A_ONE; a_d[2] = at;
      end
      SEC_CB: begin
        a_d[0] = ap;    a_d[1] = aq;    a_d[2] = A_ONE;
      end
      SEC_BM: begin
        a_d[0] = at;    a_d[1] = ap;    a_d[2] = A_ONE;
      end
      default: begin
        a_d[0] = A_ONE; a_d[1] = ap;    a_d[2] = aq;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SEL]) begin
      a_q <= a_d;
    end
  end

  // times v, then floor(x * 255 / 2^SH)
  logic [P_W-1:0]    p_q  [3];
  logic [SC_W-1:0]   sc   [3];
  logic [CHAN_W-1:0] rgb_q [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign sc[c] = {p_q[c], {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, p_q[c]};

    always_ff @(posedge clk_i) begin
      if (en[ST_MUL]) begin
        p_q[c] <= P_W'(a_q[c]) * P_W'(v_c);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_OUT]) begin
        rgb_q[c] <= sc[c][SH+CHAN_W-1:SH];
      end
    end
  end

  assign m_axis_tdata = {rgb_q[2], rgb_q[1], rgb_q[0]};

  // checks
  a_ready_follows_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STAGES-1] |-> (sec_q[DIV_STAGES-1] < SECTOR_COUNT))
    else $error("hue sextant out of range");

  a_occupancy_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && m_axis_tready))
      |=> ($countones(vld_q) == $past($countones(vld_q)) + 1))
    else $error("transaction lost or duplicated in the pipeline");

  a_empty_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (vld_q == '0)) |-> ##NUM_ST m_axis_tvalid)
    else $error("transaction did not reach the output after the pipeline latency");

endmodule

// ----- tb/palette_color_checker.sv -----
// palette_color_checker: watches the register port and both streams of the palette color block
// predicts each color from its own copy of the registers and compares field by field
// depends on iphsv_pkg

module palette_color_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [iphsv_pkg::ADDR_W-1:0]  paddr,
  input  logic [iphsv_pkg::DATA_W-1:0]  pwdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [iphsv_pkg::IN_W-1:0]    s_tdata,   // color_index[15:0]
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [iphsv_pkg::OUT_W-1:0]   m_tdata,   // red[7:0], green[15:8], blue[23:16]
  output int unsigned                   pending_o,
  output int unsigned                   mismatch_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import iphsv_pkg::*;

  localparam int unsigned FRAC = FRACTION_BITS_DEF;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  logic [SIZE_W-1:0] size_q;
  logic [CFG_W-1:0]  sat_q;
  logic [CFG_W-1:0]  val_q;
  rgb_t              expected_colors[$];

  // floor(x * 255) for x scaled by 2^(32 + FRAC)
  function automatic logic [CHAN_W-1:0] to_channel(input logic [63:0] x);
    logic [63:0] acc;
    acc = (x >> 16) * 64'd255 + (((x & 64'hFFFF) * 64'd255) >> 16);
    acc = acc >> (16 + FRAC);
    return (acc > 64'd255) ? 8'hFF : acc[CHAN_W-1:0];
  endfunction

  function automatic rgb_t palette_rgb(input logic [IN_W-1:0] idx);
    logic [63:0] n, s, v, num, f, one, cv, cp, cq, ct;
    sector_e     sec;
    rgb_t        c;
    one = 64'(CFG_ONE);
    n   = (size_q == '0) ? 64'd1 : 64'(size_q);
    s   = (64'(sat_q) > one) ? one : 64'(sat_q);
    v   = (64'(val_q) > one) ? one : 64'(val_q);
    num = (64'(idx) * 64'd2 + 64'd1) * 64'd3;
    sec = sector_e'(SEC_W'((num / n) % 64'd6));
    f   = ((num % n) << FRAC) / n;
    cv  = (v * one) << FRAC;
    cp  = (v * (one - s)) << FRAC;
    cq  = v * ((one << FRAC) - f * s);
    ct  = v * ((one << FRAC) - ((64'd1 << FRAC) - f) * s);
    case (sec)
      SEC_RY: begin c.red = to_channel(cv); c.green = to_channel(ct); c.blue = to_channel(cp); end
      SEC_YG: begin c.red = to_channel(cq); c.green = to_channel(cv); c.blue = to_channel(cp); end
      SEC_GC: begin c.red = to_channel(cp); c.green = to_channel(cv); c.blue = to_channel(ct); end
      SEC_CB: begin c.red = to_channel(cp); c.green = to_channel(cq); c.blue = to_channel(cv); end
      SEC_BM: begin c.red = to_channel(ct); c.green = to_channel(cp); c.blue = to_channel(cv); end
      default: begin
        c.red = to_channel(cv); c.green = to_channel(cp); c.blue = to_channel(cq);
      end
    endcase
    return c;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t got, want;
    if (!rst_ni) begin
      size_q = PALETTE_SIZE_RST;
      sat_q  = SATURATION_RST;
      val_q  = VALUE_LEVEL_RST;
      expected_colors.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = rgb_t'(m_tdata);
        if (expected_colors.size() == 0) begin
          report($sformatf("color %h with no transaction pending", m_tdata));
        end else begin
          want = expected_colors.pop_front();
          if (got.red != want.red)
            report($sformatf("red %0d, expected %0d", got.red, want.red));
          if (got.green != want.green)
            report($sformatf("green %0d, expected %0d", got.green, want.green));
          if (got.blue != want.blue)
            report($sformatf("blue %0d, expected %0d", got.blue, want.blue));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_colors.insert(expected_colors.size(), palette_rgb(s_tdata));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_PALETTE_SIZE: size_q = pwdata[SIZE_W-1:0];
          REG_SATURATION:   sat_q  = pwdata[CFG_W-1:0];
          REG_VALUE_LEVEL:  val_q  = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_colors.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for index_palette_hsv_to_rgb
// drives register writes and index transactions with random idling on both streams
// depends on iphsv_pkg, index_palette_hsv_to_rgb and palette_color_checker

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import iphsv_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_PAUSE = 50;
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;

  int unsigned        pending;
  int unsigned        mismatches;
  int unsigned        quiet_cycles = 0;
  int unsigned        src_idle_pct = 6;
  int unsigned        sink_idle_pct = 64;
  logic [SIZE_W-1:0]  cur_size = PALETTE_SIZE_RST;

  always #5 clk_i = ~clk_i;

  index_palette_hsv_to_rgb DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  palette_color_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .s_tvalid       (s_axis_tvalid),
    .s_tready       (s_axis_tready),
    .s_tdata        (s_axis_tdata),
    .m_tvalid       (m_axis_tvalid),
    .m_tready       (m_axis_tready),
    .m_tdata        (m_axis_tdata),
    .pending_o      (pending),
    .mismatch_cnt_o (mismatches)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("index_palette_hsv_to_rgb regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [1:0] slot, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {slot, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (slot == REG_PALETTE_SIZE) cur_size = data[SIZE_W-1:0];
  endtask

  task automatic push_index(input logic [IN_W-1:0] idx);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [IN_W-1:0] pick_index();
    case ($urandom_range(3))
      0, 1: return IN_W'($urandom_range(cur_size));
      2:    return IN_W'($urandom_range(3 * cur_size + 8));
      default: return IN_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_level();
    logic [CFG_W-1:0] lvl;
    case ($urandom_range(5))
      0:       lvl = CFG_ONE;
      1:       lvl = CFG_W'($urandom_range(131071));
      default: lvl = CFG_W'($urandom_range(65536));
    endcase
    return ($urandom & ~32'h1FFFF) | DATA_W'(lvl);
  endfunction

  function automatic logic [DATA_W-1:0] pick_size();
    logic [SIZE_W-1:0] sz;
    case ($urandom_range(4))
      0:       sz = SIZE_W'($urandom_range(16, 1));
      1:       sz = SIZE_W'($urandom_range(400, 17));
      2:       sz = '0;
      default: sz = SIZE_W'($urandom_range(65535));
    endcase
    return ($urandom & ~32'hFFFF) | DATA_W'(sz);
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults, single-entry palette
    push_index(16'd0);
    push_index(16'hFFFF);
    push_index(16'd1);
    wait_drained();

    // zero palette size acts as one
    cfg_write(REG_PALETTE_SIZE, 32'hFFFF_0000);
    push_index(16'd0);
    push_index(16'hFFFF);
    push_index(16'h8000);
    wait_drained();

    // full saturation and value, one index per sextant, then wrap
    cfg_write(REG_PALETTE_SIZE, 32'd6);
    cfg_write(REG_SATURATION, 32'(CFG_ONE));
    cfg_write(REG_VALUE_LEVEL, 32'(CFG_ONE));
    for (int i = 0; i < 8; i++) push_index(IN_W'(i));
    wait_drained();

    // levels above one saturate, largest palette, write to unused slot
    cfg_write(REG_PALETTE_SIZE, 32'hFFFF);
    cfg_write(REG_SATURATION, 32'h1FFFF);
    cfg_write(REG_VALUE_LEVEL, 32'h1FFFF);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    push_index(16'd0);
    push_index(16'hFFFF);
    push_index(16'h7FFF);
    wait_drained();

    // zero saturation and value, then zero saturation with value 65535
    cfg_write(REG_PALETTE_SIZE, 32'd7);
    cfg_write(REG_SATURATION, 32'd0);
    cfg_write(REG_VALUE_LEVEL, 32'd0);
    push_index(16'd3);
    push_index(16'd12);
    wait_drained();
    cfg_write(REG_VALUE_LEVEL, 32'd65535);
    push_index(16'd5);
    wait_drained();

    for (int blk = 0; blk < 9; blk++) begin
      src_idle_pct  = (blk < 3) ? 6 : (blk < 6) ? 64 : 0;
      sink_idle_pct = (blk < 3) ? 64 : (blk < 6) ? 6 : 0;
      cfg_write(REG_PALETTE_SIZE, pick_size());
      cfg_write(REG_SATURATION, pick_level());
      cfg_write(REG_VALUE_LEVEL, pick_level());
      if ($urandom_range(2) == 0) cfg_write(REG_SPARE, $urandom);
      repeat (50) push_index(pick_index());
      wait_drained();
    end

    repeat (DRAIN_PAUSE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("index_palette_hsv_to_rgb regression: pass");
    end else begin
      $display("index_palette_hsv_to_rgb regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/iphsv_pkg.sv
rtl/index_palette_hsv_to_rgb.sv
tb/palette_color_checker.sv
tb/tb_top.sv
